// ----- rtl/core/ltedge_pkg.sv -----
package ltedge_pkg;

  localparam int unsigned NODE_W    = 32;
  localparam int unsigned TOTAL_W   = 33;
  localparam int unsigned SIZE_W    = 8;
  localparam int unsigned COORD_W   = 8;
  localparam int unsigned NUM_SIZES = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned DIMS_W    = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE0    = 3'd0,
    CFG_SIZE1    = 3'd1,
    CFG_SIZE2    = 3'd2,
    CFG_SIZE3    = 3'd3,
    CFG_DIMS     = 3'd4,
    CFG_DIRECTED = 3'd5,
    CFG_MUTUAL   = 3'd6,
    CFG_WRAP     = 3'd7
  } cfg_idx_e;

  // live configuration seen by the sequencer
  typedef struct packed {
    logic [NUM_SIZES-1:0][SIZE_W-1:0] size;
    logic [DIMS_W-1:0]                dims_used;
    logic                             directed;
    logic                             mutual;
    logic                             wrap;
  } cfg_t;

  // one result item handed to the output register
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              present;
    logic              last;
    logic              fin;
  } item_t;

  // size of a dimension, dimensions past the size registers count as one
  function automatic logic [SIZE_W-1:0] size_at(
    input logic [NUM_SIZES-1:0][SIZE_W-1:0] sizes,
    input logic [2:0]                       idx
  );
    logic [SIZE_W-1:0] res;
    res = SIZE_W'(1);
    if (idx < 3'(NUM_SIZES)) begin
      res = sizes[idx[1:0]];
    end
    return res;
  endfunction

  // coordinate sits at the upper border (a zero size has no border)
  function automatic logic is_top(
    input logic [COORD_W-1:0] c,
    input logic [SIZE_W-1:0]  sz
  );
    return (sz != '0) && (c == (sz - SIZE_W'(1)));
  endfunction

endpackage

// ----- rtl/core/ltedge_cfg.sv -----
module ltedge_cfg
  import ltedge_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;

  // register file, one write per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SIZES; k++) begin
        cfg_q.size[k] <= SIZE_W'(1);
      end
      cfg_q.dims_used <= DIMS_W'(1);
      cfg_q.directed  <= 1'b0;
      cfg_q.mutual    <= 1'b0;
      cfg_q.wrap      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SIZE0:    cfg_q.size[0]   <= cfg_data_i;
        CFG_SIZE1:    cfg_q.size[1]   <= cfg_data_i;
        CFG_SIZE2:    cfg_q.size[2]   <= cfg_data_i;
        CFG_SIZE3:    cfg_q.size[3]   <= cfg_data_i;
        CFG_DIMS:     cfg_q.dims_used <= cfg_data_i[DIMS_W-1:0];
        CFG_DIRECTED: cfg_q.directed  <= cfg_data_i[0];
        CFG_MUTUAL:   cfg_q.mutual    <= cfg_data_i[0];
        CFG_WRAP:     cfg_q.wrap      <= cfg_data_i[0];
        default:      cfg_q.wrap      <= cfg_q.wrap;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/ltedge_mac.sv -----
module ltedge_mac
  import ltedge_pkg::*;
(
  input  logic [NODE_W-1:0] a_i,
  input  logic [SIZE_W-1:0] b_i,
  input  logic [NODE_W-1:0] sub_i,
  output logic [NODE_W-1:0] res_o
);

  logic [NODE_W+SIZE_W-1:0] prod;

  // shared multiply, then subtract, modulo 2^32
  always_comb begin
    prod  = (NODE_W+SIZE_W)'(a_i) * (NODE_W+SIZE_W)'(b_i);
    res_o = prod[NODE_W-1:0] - sub_i;
  end

endmodule

// ----- rtl/core/ltedge_out.sv -----
module ltedge_out
  import ltedge_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             push_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NODE_W-1:0] from_node_o,
  output logic [NODE_W-1:0] to_node_o,
  output logic              edge_present_o,
  output logic              last_of_node_o,
  output logic              finished_o
);

  logic  valid_q;
  item_t data_q;

  assign out_free_o = !valid_q || !out_stall_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= push_i.valid;
    end
  end

  // payload, loaded only with a new item
  always_ff @(posedge clk_i) begin
    if (out_free_o && push_i.valid) begin
      data_q <= push_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign from_node_o    = data_q.from_node;
  assign to_node_o      = data_q.to_node;
  assign edge_present_o = data_q.present;
  assign last_of_node_o = data_q.last;
  assign finished_o     = data_q.fin;

endmodule

// ----- rtl/core/ltedge_seq.sv -----
module ltedge_seq
  import ltedge_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  restart_i,
  input  logic  out_free_i,
  output item_t push_o
);

  localparam int unsigned DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned ND_W   = $clog2(MAX_DIMS + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RESTART = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_MUL     = 7'b0001000,
    S_FWD     = 7'b0010000,
    S_BWD     = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [DIDX_W-1:0]    d_q, d_d;
  logic [NODE_W-1:0]    node_q, node_d;
  logic [TOTAL_W-1:0]   total_q, total_d;
  logic [NODE_W-1:0]    acc_q, acc_d;
  logic [NODE_W-1:0]    woff_q, woff_d;
  logic [NODE_W-1:0]    stride_q [MAX_DIMS];
  logic [NODE_W-1:0]    stride_d [MAX_DIMS];
  logic [COORD_W-1:0]   coord_q [MAX_DIMS];
  logic [COORD_W-1:0]   coord_d [MAX_DIMS];
  logic                 pend_valid_q, pend_valid_d;
  logic [NODE_W-1:0]    pend_to_q, pend_to_d;

  logic [ND_W-1:0]      nd;
  logic [SIZE_W-1:0]    sz;
  logic [COORD_W-1:0]   c;
  logic [NODE_W-1:0]    s;
  logic                 c_top, c_zero, sz_two, back;
  logic                 fwd_emit, bwd_emit, cand_emit;
  logic [NODE_W-1:0]    fwd_to, bwd_to, cand_to;
  logic                 last_dim;
  logic [NODE_W-1:0]    mac_a, mac_sub, mac_res;
  logic                 accept;

  // active dimension count, saturated to the storage depth
  assign nd = (4'(cfg_i.dims_used) > 4'(MAX_DIMS)) ? ND_W'(MAX_DIMS)
                                                   : ND_W'(cfg_i.dims_used);

  // per-dimension operands
  assign sz       = size_at(cfg_i.size, 3'(d_q));
  assign c        = coord_q[d_q];
  assign s        = stride_q[d_q];
  assign c_top    = is_top(c, sz);
  assign c_zero   = (c == '0);
  assign sz_two   = (sz == SIZE_W'(2));
  assign back     = cfg_i.directed && cfg_i.mutual;
  assign last_dim = ((ND_W'(d_q) + ND_W'(1)) == nd);

  // forward edge, wrap target uses (size-1)*stride
  assign fwd_to   = !c_top ? (node_q + s) : (node_q - woff_q);
  assign fwd_emit = (cfg_i.wrap || !c_top) && (fwd_to != node_q)
                    && !(sz_two && (c == COORD_W'(1)));

  // backward edge, no self-edge check
  assign bwd_to   = !c_zero ? (node_q - s) : (node_q + woff_q);
  assign bwd_emit = back && (cfg_i.wrap || !c_zero) && !(sz_two && c_zero);

  assign cand_emit = (state_q == S_FWD) ? fwd_emit : bwd_emit;
  assign cand_to   = (state_q == S_FWD) ? fwd_to : bwd_to;

  // shared unit: stride products on restart, wrap offsets per dimension
  assign mac_a   = (state_q == S_RESTART) ? acc_q : s;
  assign mac_sub = (state_q == S_RESTART) ? '0 : s;

  ltedge_mac u_mac (
    .a_i   (mac_a),
    .b_i   (sz),
    .sub_i (mac_sub),
    .res_o (mac_res)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // sequencer
  always_comb begin
    logic carry;
    state_d      = state_q;
    d_d          = d_q;
    node_d       = node_q;
    total_d      = total_q;
    acc_d        = acc_q;
    woff_d       = woff_q;
    stride_d     = stride_q;
    coord_d      = coord_q;
    pend_valid_d = pend_valid_q;
    pend_to_d    = pend_to_q;
    push_o       = '0;
    carry        = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          d_d = '0;
          if (restart_i) begin
            node_d  = '0;
            total_d = TOTAL_W'(1);
            acc_d   = NODE_W'(1);
            for (int k = 0; k < MAX_DIMS; k++) begin
              coord_d[k] = '0;
            end
            state_d = S_RESTART;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_RESTART: begin
        stride_d[d_q] = acc_q;
        acc_d         = mac_res;
        if (last_dim) begin
          total_d = TOTAL_W'(mac_res);
        end
        if (d_q == DIDX_W'(MAX_DIMS - 1)) begin
          d_d     = '0;
          state_d = S_CHECK;
        end else begin
          d_d = d_q + DIDX_W'(1);
        end
      end
      S_CHECK: begin
        if (TOTAL_W'(node_q) >= total_q) begin
          if (out_free_i) begin
            push_o.valid = 1'b1;
            push_o.fin   = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (nd == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        woff_d  = mac_res;
        state_d = S_FWD;
      end
      S_FWD, S_BWD: begin
        if (!cand_emit || !pend_valid_q || out_free_i) begin
          if (cand_emit) begin
            if (pend_valid_q) begin
              push_o.valid     = 1'b1;
              push_o.from_node = node_q;
              push_o.to_node   = pend_to_q;
              push_o.present   = 1'b1;
            end
            pend_valid_d = 1'b1;
            pend_to_d    = cand_to;
          end
          if (state_q == S_FWD) begin
            state_d = S_BWD;
          end else if (last_dim) begin
            state_d = S_DONE;
          end else begin
            d_d     = d_q + DIDX_W'(1);
            state_d = S_MUL;
          end
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          push_o.valid     = 1'b1;
          push_o.from_node = node_q;
          push_o.to_node   = pend_valid_q ? pend_to_q : '0;
          push_o.present   = pend_valid_q;
          push_o.last      = 1'b1;
          pend_valid_d     = 1'b0;
          node_d           = node_q + NODE_W'(1);
          // mixed-radix increment over the active dimensions
          for (int k = 0; k < MAX_DIMS; k++) begin
            if (carry && (ND_W'(k) < nd)) begin
              if (!is_top(coord_q[k], size_at(cfg_i.size, 3'(k)))) begin
                coord_d[k] = coord_q[k] + COORD_W'(1);
                carry      = 1'b0;
              end else begin
                coord_d[k] = '0;
              end
            end
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      d_q          <= '0;
      node_q       <= '0;
      total_q      <= TOTAL_W'(1);
      pend_valid_q <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        coord_q[k]  <= '0;
        stride_q[k] <= (k == 0) ? NODE_W'(1) : '0;
      end
    end else begin
      state_q      <= state_d;
      d_q          <= d_d;
      node_q       <= node_d;
      total_q      <= total_d;
      pend_valid_q <= pend_valid_d;
      coord_q      <= coord_d;
      stride_q     <= stride_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    woff_q    <= woff_d;
    pend_to_q <= pend_to_d;
  end

  // a held edge exists only while a node is being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == S_MUL || state_q == S_FWD ||
                      state_q == S_BWD || state_q == S_DONE))
    else $error("held edge outside a node walk");

  // never push into a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> out_free_i)
    else $error("item pushed while output register busy");

  // a finished item never carries a held edge along
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.fin) |-> (!pend_valid_q && !push_o.present))
    else $error("finished item with an edge");

  // a restart item always recomputes the strides
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> (state_q == S_RESTART && d_q == '0))
    else $error("restart did not enter stride pass");

  // the last item of a node leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.last) |=> (state_q == S_IDLE && !pend_valid_q))
    else $error("node end did not return to idle");

endmodule

// ----- rtl/core/lattice_torus_edge_generator.sv -----
// Grid / torus edge generator.
// Input channel (in_valid_i / in_stall_o, payload restart_i): each item is
// one tick. restart_i = 1 clears the walk, recomputes strides and the node
// count from the registers, then handles node zero; restart_i = 0 handles
// the next node. Each tick gives one or more output items (valid/stall):
// one per edge, last_of_node_o on the final one, a single empty item for a
// node without edges, or a single finished item once all nodes are done.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
// while the block is idle.
// Steps: a tick is taken, then a check state, then per active dimension a
// multiply on the shared unit for the wrap offset, a forward and a
// backward slot, and a close step for the node; the walk waits in these
// steps while an item is ready and the output register is full. A tick
// past the last node ends at the check state. A restart adds a stride pass
// over all MAX_DIMS dimensions, one multiply per dimension on the same unit.
// The input stalls for the whole walk of a tick. When the receiver stalls,
// the walk waits on the output register with at most one edge held back.
// Reset returns the registers to a one-node lattice and clears the walk.
module lattice_torus_edge_generator
  import ltedge_pkg::*;
#(
  parameter int unsigned MAX_DIMS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [NODE_W-1:0]    from_node_o,
  output logic [NODE_W-1:0]    to_node_o,
  output logic                 edge_present_o,
  output logic                 last_of_node_o,
  output logic                 finished_o
);

  cfg_t  cfg;
  item_t push;
  logic  out_free;

  // configuration registers
  ltedge_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // walk sequencer with shared multiply unit
  ltedge_seq #(
    .MAX_DIMS (MAX_DIMS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_free_i (out_free),
    .push_o     (push)
  );

  // output register
  ltedge_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .from_node_o    (from_node_o),
    .to_node_o      (to_node_o),
    .edge_present_o (edge_present_o),
    .last_of_node_o (last_of_node_o),
    .finished_o     (finished_o)
  );

endmodule
